// ===== sv/led_flash_pattern_sequencer_unit_defines.svh =====
// assertion macros for the led flash pattern sequencer
// expects signals named clock and reset in the module that uses them
`ifndef LED_FLASH_PATTERN_SEQUENCER_UNIT_DEFINES_SVH
`define LED_FLASH_PATTERN_SEQUENCER_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
// checked on every clock edge outside reset
`define LFPS_ASSERT(label, prop) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) \
      else $error("lfps assertion failed");
// checked on the clock edge after a condition, outside reset
`define LFPS_ASSERT_NEXT(label, cond, prop) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (prop)) \
      else $error("lfps assertion failed");
`else
`define LFPS_ASSERT(label, prop)
`define LFPS_ASSERT_NEXT(label, cond, prop)
`endif
`endif

// ===== sv/lfps_pkg.sv =====
// shared types and constants for the led flash pattern sequencer
// no dependencies
package lfps_pkg;

   localparam int MODE_W  = 4;
   localparam int TICK_W  = 7;
   localparam int PHASE_W = 6;
   localparam int KEY_W   = 8;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 8;

   typedef logic [MODE_W-1:0]  mode_type;
   typedef logic [TICK_W-1:0]  tick_type;
   typedef logic [PHASE_W-1:0] phase_type;
   typedef logic [KEY_W-1:0]   key_type;

   // pattern state handed to and from the pattern logic
   typedef struct packed {
      tick_type  tick;
      phase_type phase;
      logic      led_a;
      logic      led_b;
   } pat_type;

   // csr register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_START_MODE = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_PRESS_MIN  = 1'b1;

   localparam mode_type MODE_MIN      = 4'd1;
   localparam mode_type MODE_MAX      = 4'd10;
   localparam key_type  KEY_SAT       = 8'd200;
   localparam key_type  PRESS_MIN_RST = 8'd8;

   // pattern modes
   localparam mode_type MODE_PULSE_ALT  = 4'd1;
   localparam mode_type MODE_STEADY     = 4'd2;
   localparam mode_type MODE_SWAP       = 4'd3;
   localparam mode_type MODE_WALK       = 4'd4;
   localparam mode_type MODE_PULSE_SLOW = 4'd5;
   localparam mode_type MODE_PULSE_BOTH = 4'd6;
   localparam mode_type MODE_BLINK      = 4'd7;
   localparam mode_type MODE_BAND_A     = 4'd8;
   localparam mode_type MODE_BAND_B     = 4'd9;
   localparam mode_type MODE_PULSE_FAST = 4'd10;

endpackage

// ===== sv/lfps_pattern.sv =====
// per-tick pattern logic: next counters and led values for the active mode
// depends on lfps_pkg
module lfps_pattern
   import lfps_pkg::*;
(
   input  mode_type mode,
   input  pat_type  cur,
   output pat_type  nxt
);

   logic [TICK_W:0]    tick_inc;
   logic [PHASE_W:0]   phase_inc;
   logic [PHASE_W:0]   phase_ext;
   logic [PHASE_W:0]   p_split;
   logic [PHASE_W:0]   p_end;
   logic               p_a1, p_b1, p_a2, p_b2, p_both;
   tick_type           p_off;
   logic [TICK_W:0]    p_last;

   assign tick_inc  = {1'b0, cur.tick} + {{TICK_W{1'b0}}, 1'b1};
   assign phase_inc = {1'b0, cur.phase} + {{PHASE_W{1'b0}}, 1'b1};
   assign phase_ext = {1'b0, cur.phase};

   // pulse pattern shape per mode
   always_comb begin
      p_split = 7'd10;
      p_end   = 7'd20;
      p_a1    = 1'b1;
      p_b1    = 1'b0;
      p_a2    = 1'b0;
      p_b2    = 1'b1;
      p_off   = 7'd3;
      p_last  = 8'd4;
      p_both  = 1'b0;
      case (mode)
         MODE_PULSE_SLOW: begin
            p_split = 7'd6;
            p_end   = 7'd12;
            p_off   = 7'd5;
            p_last  = 8'd8;
         end
         MODE_PULSE_BOTH: begin
            p_split = 7'd6;
            p_end   = 7'd10;
            p_b1    = 1'b1;
            p_b2    = 1'b0;
            p_off   = 7'd5;
            p_last  = 8'd8;
            p_both  = 1'b1;
         end
         MODE_PULSE_FAST: begin
            p_end   = 7'd17;
            p_b1    = 1'b1;
            p_b2    = 1'b0;
            p_both  = 1'b1;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      nxt = cur;
      case (mode) inside
         MODE_PULSE_ALT, MODE_PULSE_SLOW, MODE_PULSE_BOTH, MODE_PULSE_FAST: begin
            if (phase_ext < p_split) begin
               if (cur.tick == 7'd0) begin
                  nxt.led_a = p_a1;
                  nxt.led_b = p_b1;
               end
               if (cur.tick == p_off) begin
                  nxt.led_a = 1'b0;
                  nxt.led_b = 1'b0;
               end
            end else if (p_a2 | p_b2) begin
               if (cur.tick == 7'd0) begin
                  nxt.led_a = p_a2;
                  nxt.led_b = p_b2;
               end
               if (cur.tick == p_off) begin
                  nxt.led_a = 1'b0;
                  nxt.led_b = 1'b0;
               end
            end else begin
               nxt.led_a = 1'b0;
               nxt.led_b = 1'b0;
            end
            if (tick_inc > p_last) begin
               nxt.tick = '0;
               if (phase_inc >= p_end) begin
                  nxt.phase = '0;
                  nxt.led_a = 1'b0;
                  if (p_both) begin
                     nxt.led_b = 1'b0;
                  end
               end else begin
                  nxt.phase = phase_inc[PHASE_W-1:0];
               end
            end else begin
               nxt.tick = tick_inc[TICK_W-1:0];
            end
         end
         MODE_STEADY: begin
            nxt.led_a = 1'b1;
            nxt.led_b = 1'b1;
         end
         MODE_SWAP: begin
            if (cur.phase < 6'd10) begin
               nxt.led_a = (cur.tick >= 7'd20);
               nxt.led_b = (cur.tick < 7'd20);
               if (tick_inc >= 8'd41) begin
                  nxt.phase = phase_inc[PHASE_W-1:0];
                  nxt.tick  = '0;
                  nxt.led_a = 1'b0;
                  nxt.led_b = 1'b0;
               end else begin
                  nxt.tick = tick_inc[TICK_W-1:0];
               end
            end else begin
               nxt.led_a = (cur.tick >= 7'd6);
               nxt.led_b = (cur.tick < 7'd6);
               if (tick_inc >= 8'd11) begin
                  nxt.tick = '0;
                  nxt.phase = (phase_inc >= 7'd20) ? '0 : phase_inc[PHASE_W-1:0];
               end else begin
                  nxt.tick = tick_inc[TICK_W-1:0];
               end
            end
         end
         MODE_WALK: begin
            if (cur.tick < 7'd13) begin
               nxt.led_a = 1'b1; nxt.led_b = 1'b0;
            end else if (cur.tick < 7'd26) begin
               nxt.led_a = 1'b0; nxt.led_b = 1'b0;
            end else if (cur.tick < 7'd39) begin
               nxt.led_a = 1'b1; nxt.led_b = 1'b0;
            end else if (cur.tick < 7'd52) begin
               nxt.led_a = 1'b0; nxt.led_b = 1'b0;
            end else if (cur.tick < 7'd65) begin
               nxt.led_a = 1'b0; nxt.led_b = 1'b1;
            end else if (cur.tick < 7'd78) begin
               nxt.led_a = 1'b0; nxt.led_b = 1'b0;
            end else if (cur.tick < 7'd91) begin
               nxt.led_a = 1'b0; nxt.led_b = 1'b1;
            end else if (cur.tick < 7'd104) begin
               nxt.led_a = 1'b0; nxt.led_b = 1'b0;
            end
            nxt.tick = (tick_inc >= 8'd104) ? '0 : tick_inc[TICK_W-1:0];
         end
         MODE_BLINK: begin
            if (cur.phase < 6'd11) begin
               nxt.led_a = cur.phase[0];
               nxt.led_b = cur.phase[0];
               if (tick_inc >= 8'd50) begin
                  nxt.phase = phase_inc[PHASE_W-1:0];
                  nxt.tick  = '0;
                  nxt.led_a = 1'b0;
                  nxt.led_b = 1'b0;
               end else begin
                  nxt.tick = tick_inc[TICK_W-1:0];
               end
            end else begin
               nxt.led_a = (cur.tick < 7'd3);
               nxt.led_b = (cur.tick < 7'd3);
               if (tick_inc >= 8'd5) begin
                  nxt.tick = '0;
                  nxt.phase = (phase_inc >= 7'd51) ? '0 : phase_inc[PHASE_W-1:0];
               end else begin
                  nxt.tick = tick_inc[TICK_W-1:0];
               end
            end
         end
         MODE_BAND_A, MODE_BAND_B: begin
            // both on in two bands, the mode's own led elsewhere
            if ((cur.tick >= 7'd44 && cur.tick < 7'd57) ||
                (cur.tick >= 7'd70 && cur.tick < 7'd83)) begin
               nxt.led_a = 1'b1;
               nxt.led_b = 1'b1;
            end else if (cur.tick < 7'd96) begin
               nxt.led_a = (mode == MODE_BAND_A);
               nxt.led_b = (mode == MODE_BAND_B);
            end
            nxt.tick = (tick_inc >= 8'd96) ? '0 : tick_inc[TICK_W-1:0];
         end
         default: begin
         end
      endcase
   end

endmodule

// ===== sv/led_flash_pattern_sequencer_unit.sv =====
// led flash pattern sequencer top level: key press detect, mode advance,
// state registers and result register; depends on lfps_pkg, lfps_pattern
// and the assertion macro header
// a tick transferred at an edge shows its result in the result register the cycle after
// throughput: one tick per cycle; a held result or an offered register write stalls ticks
// reset: mode 1, all counters and both leds cleared, press threshold 8, no result held
`include "led_flash_pattern_sequencer_unit_defines.svh"
module led_flash_pattern_sequencer_unit
   import lfps_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // tick input
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic                  req_key_level,
   // result output
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic                  rsp_led_a,
   output logic                  rsp_led_b,
   output mode_type              rsp_current_mode,
   output logic                  rsp_mode_changed,
   // register writes
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   // state
   mode_type  mode_ff;
   tick_type  tick_ff;
   phase_type phase_ff;
   key_type   key_ff;
   logic      led_a_ff;
   logic      led_b_ff;
   key_type   press_min_ff;

   // result register
   logic      rsp_valid_ff;
   logic      rsp_led_a_ff;
   logic      rsp_led_b_ff;
   mode_type  rsp_mode_ff;
   logic      rsp_changed_ff;

   logic      req_xfer;
   logic      csr_xfer;
   logic      changed;
   key_type   key_in;
   mode_type  mode_in;
   mode_type  mode_adv;
   mode_type  start_mode;
   logic [KEY_W:0] key_inc;
   pat_type   pat_cur;
   pat_type   pat_in;

   // a tick can enter whenever the result register is empty or draining,
   // and waits while a register write is offered
   assign req_stall = (rsp_valid_ff & rsp_stall) | csr_valid;
   assign req_xfer  = req_valid & ~req_stall;
   assign csr_ready = 1'b1;
   assign csr_xfer  = csr_valid & csr_ready;

   // key counter saturates; a release after enough held ticks is a press
   assign key_inc = {1'b0, key_ff} + {{KEY_W{1'b0}}, 1'b1};
   always_comb begin
      changed = 1'b0;
      if (req_key_level) begin
         key_in = (key_inc >= {1'b0, KEY_SAT}) ? KEY_SAT : key_inc[KEY_W-1:0];
      end else begin
         key_in  = '0;
         changed = (key_ff >= press_min_ff);
      end
   end

   // mode advances 1..10 with wrap
   assign mode_adv = (mode_ff >= MODE_MAX) ? MODE_MIN : mode_ff + 4'd1;
   assign mode_in  = changed ? mode_adv : mode_ff;

   // a press restarts the pattern counters and drops led a before the pattern runs
   always_comb begin
      pat_cur.tick  = changed ? '0 : tick_ff;
      pat_cur.phase = changed ? '0 : phase_ff;
      pat_cur.led_a = changed ? 1'b0 : led_a_ff;
      pat_cur.led_b = led_b_ff;
   end

   lfps_pattern u_pattern (
      .mode (mode_in),
      .cur  (pat_cur),
      .nxt  (pat_in)
   );

   // out-of-range start mode falls back to mode 1
   assign start_mode = (csr_data[MODE_W-1:0] >= MODE_MIN &&
                        csr_data[MODE_W-1:0] <= MODE_MAX) ?
                       csr_data[MODE_W-1:0] : MODE_MIN;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_MIN;
         tick_ff      <= '0;
         phase_ff     <= '0;
         key_ff       <= '0;
         led_a_ff     <= 1'b0;
         led_b_ff     <= 1'b0;
         press_min_ff <= PRESS_MIN_RST;
      end else if (csr_xfer) begin
         unique case (csr_index)
            CSR_START_MODE: begin
               // restart as at power-up, leds and key counter kept
               mode_ff  <= start_mode;
               tick_ff  <= '0;
               phase_ff <= '0;
            end
            CSR_PRESS_MIN: begin
               press_min_ff <= csr_data[KEY_W-1:0];
            end
         endcase
      end else if (req_xfer) begin
         mode_ff  <= mode_in;
         tick_ff  <= pat_in.tick;
         phase_ff <= pat_in.phase;
         key_ff   <= key_in;
         led_a_ff <= pat_in.led_a;
         led_b_ff <= pat_in.led_b;
      end
   end

   // result valid: set by a tick transfer, cleared once the result is taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_xfer) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         rsp_led_a_ff   <= pat_in.led_a;
         rsp_led_b_ff   <= pat_in.led_b;
         rsp_mode_ff    <= mode_in;
         rsp_changed_ff <= changed;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_led_a        = rsp_led_a_ff;
   assign rsp_led_b        = rsp_led_b_ff;
   assign rsp_current_mode = rsp_mode_ff;
   assign rsp_mode_changed = rsp_changed_ff;

   // mode never leaves 1..10
   `LFPS_ASSERT(a_mode_range, mode_ff >= MODE_MIN && mode_ff <= MODE_MAX)
   // key counter stays at or below saturation
   `LFPS_ASSERT(a_key_sat, key_ff <= KEY_SAT)
   // a tick with the key held never reports a mode change
   `LFPS_ASSERT_NEXT(a_held_no_change, req_xfer && req_key_level, !rsp_changed_ff)
   // every tick transfer leaves a result behind
   `LFPS_ASSERT_NEXT(a_result_after_tick, req_xfer, rsp_valid_ff)

endmodule
